@@ src/two_target_velocity_estimator_unit_macros.svh @@
// Assertion macros for the velocity estimator
`ifndef TWO_TARGET_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define TWO_TARGET_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TVE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TVE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TVE_ASSERT(lbl, clk, rst_n, prop)
`define TVE_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ src/tve_pkg.sv @@
// Shared constants of the velocity estimator
`default_nettype none
package tve_pkg;
  localparam int unsigned PosW     = 20;
  localparam int unsigned VelW     = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned GainW    = 17;
  localparam int unsigned NumDflt  = 2;
  localparam logic [GainW-1:0] GainReset = 17'd19661;
  localparam logic [GainW-1:0] GainOne   = 17'd65536;
  localparam logic signed [VelW-1:0] VelMax = 24'sd8388607;
  localparam logic [31:0] Scale = 32'd1000000;
  // numerator: 21-bit diff * 1e6 fits in 41 bits signed
  localparam int unsigned NumW = 41;
  localparam int unsigned QuoW = 41;
  localparam logic [1:0] RegGain = 2'd0;
endpackage
`default_nettype wire

@@ src/tve_divider.sv @@
// Bit-serial restoring divider for signed numerator over positive divisor
`default_nettype none
module tve_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [tve_pkg::NumW-1:0] num_i,
  input  wire logic [tve_pkg::TimeW-1:0]     den_i,
  output logic                               done_o,
  output logic signed [tve_pkg::VelW-1:0]    quo_o
);
  import tve_pkg::*;
  logic [NumW-1:0] q_q, q_d;
  logic [TimeW:0]  r_q, r_d;
  logic [TimeW-1:0] den_q, den_d;
  logic neg_q, neg_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [TimeW:0] trial;
  logic [NumW-1:0] mag;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
    trial = {r_q[TimeW-1:0], q_q[NumW-1]} - {1'b0, den_q};
    if (start_i) begin
      q_d = mag; r_d = '0; den_d = den_i; neg_d = num_i[NumW-1];
      cnt_d = 6'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[TimeW]) begin
        r_d = trial; q_d = {q_q[NumW-2:0], 1'b1};
      end else begin
        r_d = {r_q[TimeW-1:0], q_q[NumW-1]}; q_d = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d; neg_q <= neg_d;
  end

  logic [VelW-1:0] sat;
  always_comb begin
    sat = (q_q > NumW'(VelMax)) ? VelMax : q_q[VelW-1:0];
    quo_o = neg_q ? -$signed(sat) : $signed(sat);
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

@@ src/two_target_velocity_estimator_unit.sv @@
// Top level of the two-target velocity estimator
//
// A sample that updates the velocity runs its three axes one after the other
// through one shared bit-serial divider that produces one quotient bit per
// cycle (41 bits). Each axis passes through a start state, a division wait
// state and a blend state. After the third axis, and for a sample without an
// update (first sample, non-positive dt, slot out of range), the sample
// passes through the output state before its result turns valid. The result
// is held until taken, and the next input is accepted from the cycle after
// the result transaction, so only one sample is in flight.
// Configuration writes land through an APB port; smoothing_gain sits at
// address 0 and must only be written while no sample is in flight.
`default_nettype none
module two_target_velocity_estimator_unit #(
  parameter int unsigned NUM_TARGETS = tve_pkg::NumDflt
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        target_slot_i,
  input  wire logic signed [19:0] pos_x_i,
  input  wire logic signed [19:0] pos_y_i,
  input  wire logic signed [19:0] pos_z_i,
  input  wire logic [31:0] timestamp_us_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_slot_o,
  output logic             velocity_valid_o,
  output logic signed [23:0] vel_x_o,
  output logic signed [23:0] vel_y_o,
  output logic signed [23:0] vel_z_o,
  output logic             relative_valid_o,
  output logic signed [20:0] rel_dx_o,
  output logic signed [20:0] rel_dy_o,
  output logic signed [20:0] rel_dz_o,
  output logic signed [24:0] rel_dvx_o,
  output logic signed [24:0] rel_dvy_o,
  output logic signed [24:0] rel_dvz_o
);
  import tve_pkg::*;
  `include "two_target_velocity_estimator_unit_macros.svh"

  localparam int unsigned NT = (NUM_TARGETS < 2) ? 2 : NUM_TARGETS;
  localparam logic [2:0] StIdle = 3'd0, StDiv = 3'd1, StWait = 3'd2,
                         StBlend = 3'd3, StOut = 3'd4, StHold = 3'd5;

  logic [GainW-1:0] gain_q;
  assign pready = 1'b1;
  assign prdata = (paddr == RegGain) ? 32'(gain_q) : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gain_q <= GainReset;
    else if (psel && penable && pwrite && paddr == RegGain) gain_q <= pwdata[GainW-1:0];
  end

  logic signed [PosW-1:0] lpos_q [NT][3];
  logic [TimeW-1:0] ltime_q [NT];
  logic [1:0] cnt_q [NT];
  logic signed [VelW-1:0] svel_q [NT][3];

  logic [2:0] st_q;
  logic [1:0] ax_q;
  logic slot_q, inrange_q, upd_q;
  logic [1:0] ncnt_q;
  logic signed [PosW-1:0] pos_q [3];
  logic [TimeW-1:0] ts_q, dt_q;
  logic signed [VelW-1:0] inst_q;
  logic div_start, div_done;
  logic signed [VelW-1:0] div_quo;
  logic signed [NumW-1:0] num;
  logic signed [PosW:0] diff;

  assign diff = {pos_q[ax_q][PosW-1], pos_q[ax_q]} - {lpos_q[slot_q][ax_q][PosW-1],
                lpos_q[slot_q][ax_q]};
  assign num = NumW'(diff) * $signed({1'b0, Scale[19:0]});
  assign div_start = (st_q == StDiv);

  tve_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(dt_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [GainW-1:0] g;
  logic signed [42:0] acc;
  logic signed [26:0] fl;
  assign g = (gain_q > GainOne) ? GainOne : gain_q;
  assign acc = 43'($signed({1'b0, g}) * inst_q)
             + 43'($signed({1'b0, GainOne - g}) * svel_q[slot_q][ax_q]);
  assign fl = 27'(acc >>> 16);

  assign in_ready_o = (st_q == StIdle);

  logic [TimeW-1:0] dtw;
  logic [1:0] cnew;
  assign dtw = timestamp_us_i - ltime_q[target_slot_i];
  assign cnew = (cnt_q[target_slot_i] == 2'd3) ? 2'd3 : cnt_q[target_slot_i] + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; out_valid_o <= 1'b0; ax_q <= '0;
      for (int i = 0; i < NT; i++) begin
        ltime_q[i] <= '0; cnt_q[i] <= '0;
        for (int a = 0; a < 3; a++) begin
          lpos_q[i][a] <= '0; svel_q[i][a] <= '0;
        end
      end
    end else begin
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          slot_q <= target_slot_i;
          inrange_q <= (32'(target_slot_i) < NUM_TARGETS);
          pos_q[0] <= pos_x_i; pos_q[1] <= pos_y_i; pos_q[2] <= pos_z_i;
          ts_q <= timestamp_us_i; dt_q <= dtw; ncnt_q <= cnew;
          upd_q <= (32'(target_slot_i) < NUM_TARGETS) && cnew >= 2'd2 &&
                   dtw != '0 && !dtw[TimeW-1];
          ax_q <= '0;
          st_q <= ((32'(target_slot_i) < NUM_TARGETS) && cnew >= 2'd2 &&
                   dtw != '0 && !dtw[TimeW-1]) ? StDiv : StOut;
        end
        StDiv: st_q <= StWait;
        StWait: if (div_done) begin
          inst_q <= div_quo; st_q <= StBlend;
        end
        StBlend: begin
          if (ncnt_q == 2'd2) svel_q[slot_q][ax_q] <= inst_q;
          else if (fl > 27'(VelMax)) svel_q[slot_q][ax_q] <= VelMax;
          else if (fl < -27'(VelMax)) svel_q[slot_q][ax_q] <= -VelMax;
          else svel_q[slot_q][ax_q] <= fl[VelW-1:0];
          if (ax_q == 2'd2) st_q <= StOut;
          else begin
            ax_q <= ax_q + 2'd1; st_q <= StDiv;
          end
        end
        StOut: if (!out_valid_o) begin
          if (inrange_q) begin
            for (int a = 0; a < 3; a++) lpos_q[slot_q][a] <= pos_q[a];
            ltime_q[slot_q] <= ts_q; cnt_q[slot_q] <= ncnt_q;
          end
          out_valid_o <= 1'b1;
          st_q <= StHold;
        end
        StHold: if (out_ready_i) begin
          out_valid_o <= 1'b0; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  logic rv;
  assign rv = (NUM_TARGETS >= 2) && cnt_q[0] != 2'd0 && cnt_q[1] != 2'd0;
  always_comb begin
    result_slot_o = slot_q;
    velocity_valid_o = upd_q;
    vel_x_o = inrange_q ? svel_q[slot_q][0] : '0;
    vel_y_o = inrange_q ? svel_q[slot_q][1] : '0;
    vel_z_o = inrange_q ? svel_q[slot_q][2] : '0;
    relative_valid_o = rv;
    rel_dx_o = rv ? 21'(lpos_q[0][0]) - 21'(lpos_q[1][0]) : '0;
    rel_dy_o = rv ? 21'(lpos_q[0][1]) - 21'(lpos_q[1][1]) : '0;
    rel_dz_o = rv ? 21'(lpos_q[0][2]) - 21'(lpos_q[1][2]) : '0;
    rel_dvx_o = rv ? 25'(svel_q[0][0]) - 25'(svel_q[1][0]) : '0;
    rel_dvy_o = rv ? 25'(svel_q[0][1]) - 25'(svel_q[1][1]) : '0;
    rel_dvz_o = rv ? 25'(svel_q[0][2]) - 25'(svel_q[1][2]) : '0;
  end

  `TVE_ASSERT(a_ready_idle, clk_i, rst_ni, out_valid_o |-> !in_ready_o)
  `TVE_ASSERT(a_axis_range, clk_i, rst_ni, (st_q == StBlend) |-> (ax_q != 2'd3))
  `TVE_ASSERT(a_vvalid_slot, clk_i, rst_ni, (out_valid_o && velocity_valid_o) |-> inrange_q)
endmodule
`default_nettype wire

@@ verif/two_target_velocity_estimator_unit_tb.sv @@
// Self-checking testbench of the two-target velocity estimator with a built-in velocity predictor
`timescale 1ns / 100ps
`default_nettype none
module two_target_velocity_estimator_unit_tb;
  import tve_pkg::*;

  localparam int unsigned Period = 8;
  localparam int ExpDepth = 2048;
  localparam int NumRows = 14;

  typedef struct packed {
    logic        slot;
    logic [19:0] px;
    logic [19:0] py;
    logic [19:0] pz;
    logic [31:0] ts;
  } sample_t;

  typedef struct packed {
    logic        slot;
    logic        vvalid;
    logic [23:0] vx, vy, vz;
    logic        rvalid;
    logic [20:0] dx, dy, dz;
    logic [24:0] dvx, dvy, dvz;
  } track_report_t;

  typedef struct {
    sample_t       smp;
    bit            has_exp;
    track_report_t exp_rep;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic target_slot_i;
  logic signed [19:0] pos_x_i, pos_y_i, pos_z_i;
  logic [31:0] timestamp_us_i;
  logic out_valid_o, out_ready_i;
  logic result_slot_o, velocity_valid_o, relative_valid_o;
  logic signed [23:0] vel_x_o, vel_y_o, vel_z_o;
  logic signed [20:0] rel_dx_o, rel_dy_o, rel_dz_o;
  logic signed [24:0] rel_dvx_o, rel_dvy_o, rel_dvz_o;

  two_target_velocity_estimator_unit dut (.*);

  longint       gain_q;
  longint       last_pos[2][3];
  logic [31:0]  last_ts[2];
  int           hit_count[2];
  longint       vel_est[2][3];
  track_report_t exp_pred[ExpDepth];
  track_report_t exp_fix[ExpDepth];
  bit            exp_forced[ExpDepth];
  int exp_wr, exp_rd;
  int error_count;
  int send_idle_pct, recv_idle_pct;
  logic [31:0] ts_base[2];

  function automatic longint clamp_vel(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388607) return -8388607;
    return v;
  endfunction

  function automatic longint floor_q16(longint x);
    if (x >= 0) return x / 65536;
    return -((-x + 65535) / 65536);
  endfunction

  function automatic track_report_t estimate_track(sample_t s);
    track_report_t r;
    longint p[3], g, num, inst, acc;
    logic [31:0] d;
    int c;
    r = '0;
    g = (gain_q > 65536) ? 65536 : gain_q;
    p[0] = longint'(signed'(s.px));
    p[1] = longint'(signed'(s.py));
    p[2] = longint'(signed'(s.pz));
    r.slot = s.slot;
    c = (hit_count[s.slot] >= 3) ? 3 : hit_count[s.slot] + 1;
    d = s.ts - last_ts[s.slot];
    if (c >= 2 && d != 0 && !d[31]) begin
      for (int a = 0; a < 3; a++) begin
        num = (p[a] - last_pos[s.slot][a]) * 1000000;
        inst = clamp_vel(num / longint'(d));
        if (c == 2) vel_est[s.slot][a] = inst;
        else begin
          acc = g * inst + (65536 - g) * vel_est[s.slot][a];
          vel_est[s.slot][a] = clamp_vel(floor_q16(acc));
        end
      end
      r.vvalid = 1'b1;
    end
    for (int a = 0; a < 3; a++) last_pos[s.slot][a] = p[a];
    last_ts[s.slot] = s.ts;
    hit_count[s.slot] = c;
    r.vx = vel_est[s.slot][0][23:0];
    r.vy = vel_est[s.slot][1][23:0];
    r.vz = vel_est[s.slot][2][23:0];
    if (hit_count[0] > 0 && hit_count[1] > 0) begin
      r.rvalid = 1'b1;
      r.dx = 21'(last_pos[0][0] - last_pos[1][0]);
      r.dy = 21'(last_pos[0][1] - last_pos[1][1]);
      r.dz = 21'(last_pos[0][2] - last_pos[1][2]);
      r.dvx = 25'(vel_est[0][0] - vel_est[1][0]);
      r.dvy = 25'(vel_est[0][1] - vel_est[1][1]);
      r.dvz = 25'(vel_est[0][2] - vel_est[1][2]);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(Period / 2) clk_i = ~clk_i;
  end

  initial begin
    #(Period * 6_000_000);
    $display("two_target_velocity_estimator_unit_tb: errors");
    $finish;
  end

  // sink: random stalls, compare against the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    track_report_t got, want;
    int idx;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_slot_o, velocity_valid_o, vel_x_o, vel_y_o, vel_z_o, relative_valid_o,
              rel_dx_o, rel_dy_o, rel_dz_o, rel_dvx_o, rel_dvy_o, rel_dvz_o};
      if (exp_rd == exp_wr) report_mismatch("unexpected transaction", got.slot, 0);
      else begin
        idx = exp_rd % ExpDepth;
        want = exp_forced[idx] ? exp_fix[idx] : exp_pred[idx];
        exp_rd++;
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.vvalid != want.vvalid) report_mismatch("velocity_valid", got.vvalid, want.vvalid);
        if (got.vx != want.vx) report_mismatch("vel_x", got.vx, want.vx);
        if (got.vy != want.vy) report_mismatch("vel_y", got.vy, want.vy);
        if (got.vz != want.vz) report_mismatch("vel_z", got.vz, want.vz);
        if (got.rvalid != want.rvalid) report_mismatch("relative_valid", got.rvalid, want.rvalid);
        if (got.dx != want.dx) report_mismatch("rel_dx", got.dx, want.dx);
        if (got.dy != want.dy) report_mismatch("rel_dy", got.dy, want.dy);
        if (got.dz != want.dz) report_mismatch("rel_dz", got.dz, want.dz);
        if (got.dvx != want.dvx) report_mismatch("rel_dvx", got.dvx, want.dvx);
        if (got.dvy != want.dvy) report_mismatch("rel_dvy", got.dvy, want.dvy);
        if (got.dvz != want.dvz) report_mismatch("rel_dvz", got.dvz, want.dvz);
      end
    end
  end

  task automatic write_gain(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegGain; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    gain_q = longint'(value[16:0]);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_sample(sample_t s, bit has_exp, track_report_t exp_rep);
    track_report_t r;
    int idx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {target_slot_i, pos_x_i, pos_y_i, pos_z_i, timestamp_us_i} <= s;
    do @(posedge clk_i); while (!in_ready_o);
    r = estimate_track(s);
    idx = exp_wr % ExpDepth;
    exp_pred[idx] = r;
    exp_forced[idx] = has_exp;
    exp_fix[idx] = exp_rep;
    exp_wr++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (exp_rd != exp_wr && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic sample_t rand_sample(bit slot, bit wild);
    sample_t s;
    int step;
    s.slot = slot;
    if (wild) begin
      s.px = 20'($urandom); s.py = 20'($urandom); s.pz = 20'($urandom); s.ts = $urandom;
    end else begin
      step = $urandom_range(5) == 0 ? $urandom_range(3) : $urandom_range(200_000, 1);
      s.ts = ts_base[slot] + step;
      if ($urandom_range(30) == 0) s.ts = ts_base[slot] - $urandom_range(1000);
      s.px = 20'(last_pos[slot][0] + $signed($urandom_range(8000)) - 4000);
      s.py = 20'(last_pos[slot][1] + $signed($urandom_range(8000)) - 4000);
      s.pz = 20'(last_pos[slot][2] + $signed($urandom_range(8000)) - 4000);
    end
    return s;
  endfunction

  initial begin
    stim_row_t rows[NumRows];
    track_report_t blank;
    sample_t s;
    logic [31:0] gains[6];
    bit slot;
    error_count = 0;
    exp_wr = 0; exp_rd = 0;
    send_idle_pct = 9; recv_idle_pct = 75;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b0;
    {target_slot_i, pos_x_i, pos_y_i, pos_z_i, timestamp_us_i} = '0;
    gain_q = 19661;
    for (int i = 0; i < 2; i++) begin
      last_ts[i] = '0; hit_count[i] = 0; ts_base[i] = '0;
      for (int a = 0; a < 3; a++) begin last_pos[i][a] = 0; vel_est[i][a] = 0; end
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    blank = '0;
    // first sample of target 0: nothing relative yet
    rows[0] = '{'{1'b0, 20'sd100, -20'sd100, 20'sd0, 32'd1000}, 1'b1, blank};
    rows[1] = '{'{1'b1, 20'h7FFFF, 20'h80000, 20'h7FFFF, 32'hFFFF_FFFF}, 1'b0, blank};
    rows[2] = '{'{1'b0, 20'h80000, 20'h7FFFF, 20'h80000, 32'd1001}, 1'b0, blank};
    rows[3] = '{'{1'b0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 32'd1001}, 1'b0, blank};
    rows[4] = '{'{1'b0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 32'd900}, 1'b0, blank};
    rows[5] = '{'{1'b0, 20'h0, 20'h0, 20'h0, 32'h8000_0384}, 1'b0, blank};
    rows[6] = '{'{1'b0, 20'h10, 20'h0, 20'h5, 32'h8000_0385}, 1'b0, blank};
    rows[7] = '{'{1'b1, 20'h0, 20'h0, 20'h0, 32'h7FFF_FFFE}, 1'b0, blank};
    rows[8] = '{'{1'b1, 20'h100, 20'hFFF00, 20'h1, 32'h7FFF_FFFF}, 1'b0, blank};
    rows[9] = '{'{1'b1, 20'h200, 20'hFFE00, 20'h3, 32'h8000_0001}, 1'b0, blank};
    rows[10] = '{'{1'b1, 20'h300, 20'h0, 20'h5, 32'h8100_0001}, 1'b0, blank};
    rows[11] = '{'{1'b0, 20'h7FFFF, 20'h80000, 20'h1234, 32'h8000_1385}, 1'b0, blank};
    rows[12] = '{'{1'b0, 20'h55555, 20'hAAAAA, 20'h0F0F0, 32'hA5A5_5A5A}, 1'b0, blank};
    rows[13] = '{'{1'b1, 20'hAAAAA, 20'h55555, 20'hF0F0F, 32'h5A5A_A5A5}, 1'b0, blank};
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].has_exp, rows[i].exp_rep);
    drain();

    gains = '{32'd65536, 32'd0, 32'h1FFFF, 32'd19661, 32'd1, 32'd40000};
    for (int ph = 0; ph < 6; ph++) begin
      write_gain(gains[ph]);
      if (ph == 2) begin send_idle_pct = 75; recv_idle_pct = 9; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      ts_base[0] = last_ts[0]; ts_base[1] = last_ts[1];
      for (int n = 0; n < 190; n++) begin
        slot = 1'($urandom_range(1));
        s = rand_sample(slot, $urandom_range(9) == 0);
        ts_base[slot] = s.ts;
        send_sample(s, 1'b0, blank);
        if (n == 95 && ph == 1) drain();
      end
      drain();
    end

    if (error_count == 0) $display("two_target_velocity_estimator_unit_tb: clean");
    else $display("two_target_velocity_estimator_unit_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/tve_pkg.sv
src/tve_divider.sv
src/two_target_velocity_estimator_unit.sv
verif/two_target_velocity_estimator_unit_tb.sv
